// ===== rtl/bsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

	typedef enum logic [2:0] {
		CMD_AND    = 3'd0,
		CMD_OR     = 3'd1,
		CMD_NOT    = 3'd2,
		CMD_SHIFT  = 3'd3,
		CMD_ROTATE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		DM_BIN   = 2'd0,
		DM_OCT   = 2'd1,
		DM_HEX   = 2'd2,
		DM_UNDEF = 2'd3
	} digit_mode_t;

	localparam int CNT_W      = 32;
	localparam int REM_STEP_W = 8;
	localparam int LEN_PORT_W = 7;
	// input accept to result strobe
	localparam int LATENCY    = 6;

	function automatic logic [2:0] digit_bits(input digit_mode_t mode);
		logic [2:0] nb;
		unique case (mode)
			DM_BIN:  nb = 3'd1;
			DM_HEX:  nb = 3'd4;
			default: nb = 3'd3;
		endcase
		return nb;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bsl_rem_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// eight restoring remainder steps, one dividend bit each, msb first
module bsl_rem_stage
	import bsl_pkg::*;
#(
	parameter int DVW = 7
) (
	input  wire logic [DVW-1:0]        cur_rem,
	input  wire logic [REM_STEP_W-1:0] dividend_bits,
	input  wire logic [DVW-1:0]        divisor,
	output logic      [DVW-1:0]        next_rem
);

	always_comb begin
		logic [DVW:0] t;
		logic [DVW-1:0] r;
		r = cur_rem;
		for (int i = REM_STEP_W - 1; i >= 0; i--) begin
			t = {r, dividend_bits[i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[DVW-1:0];
		end
		next_rem = r;
	end

endmodule

`default_nettype wire

// ===== rtl/bit_string_logic_shift_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake               payload
// item in   in   start & !busy           cmd, operand_a, len_a, operand_b, len_b, shift_count
// result    out  done, one cycle         result, result_len
// config    in   cfg_wr_en               cfg_wr_data (digit mode, value 3 ignored)
//
// every accepted item gives one result, in order; one item per cycle.
// the depth comes from the rotate remainder: after the length stage, 32 count bits, 8 steps
// in each of 4 stages, then one stage for the shifters and the output register.
// busy is always low; results cannot be held off, so nothing stalls.
// reset clears the valid bits, the strobe and sets the digit mode to octal.
module bit_string_logic_shift_unit
	import bsl_pkg::*;
#(
	parameter int VECTOR_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            cmd,
	input  wire logic [63:0]           operand_a,
	input  wire logic [LEN_PORT_W-1:0] len_a,
	input  wire logic [63:0]           operand_b,
	input  wire logic [LEN_PORT_W-1:0] len_b,
	input  wire logic signed [31:0]    shift_count,
	input  wire logic                  cfg_wr_en,
	input  wire logic [1:0]            cfg_wr_data,
	output logic                       done,
	output logic [63:0]                result,
	output logic [LEN_PORT_W-1:0]      result_len
);

	localparam int DW    = (VECTOR_BITS < 64) ? VECTOR_BITS : 64;
	localparam int LW    = $clog2(DW + 1);
	localparam int MAXD1 = DW;
	localparam int MAXD3 = DW / 3;
	localparam int MAXD4 = DW / 4;

	digit_mode_t digit_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_mode_q <= DM_OCT;
		end else if (cfg_wr_en && (digit_mode_t'(cfg_wr_data) != DM_UNDEF)) begin
			digit_mode_q <= digit_mode_t'(cfg_wr_data);
		end
	end

	assign busy = 1'b0;

	// stage 1: length saturation and bit lengths
	logic [2:0]            nbits;
	logic [LEN_PORT_W-1:0] maxd;
	logic [LEN_PORT_W-1:0] la_sat, lb_sat;
	logic [CNT_W-1:0]      cnt_mag;

	always_comb begin
		nbits = digit_bits(digit_mode_q);
		unique case (digit_mode_q)
			DM_BIN:  maxd = LEN_PORT_W'(MAXD1);
			DM_HEX:  maxd = LEN_PORT_W'(MAXD4);
			default: maxd = LEN_PORT_W'(MAXD3);
		endcase
		if (len_a == '0)       la_sat = LEN_PORT_W'(1);
		else if (len_a > maxd) la_sat = maxd;
		else                   la_sat = len_a;
		if (len_b == '0)       lb_sat = LEN_PORT_W'(1);
		else if (len_b > maxd) lb_sat = maxd;
		else                   lb_sat = len_b;
		// negating the most negative count gives itself, which is the magnitude
		cnt_mag = shift_count[CNT_W-1] ? (~shift_count + 1'b1) : shift_count;
	end

	logic                 vld_s1;
	cmd_t                 cmd_s1;
	logic [DW-1:0]        a_s1, b_s1;
	logic [LW-1:0]        la_s1, lb_s1, nba_s1, nbb_s1;
	logic                 neg_s1;
	logic [CNT_W-1:0]     mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_t'(cmd);
		a_s1   <= operand_a[DW-1:0];
		b_s1   <= operand_b[DW-1:0];
		la_s1  <= LW'(la_sat);
		lb_s1  <= LW'(lb_sat);
		nba_s1 <= LW'(la_sat * nbits);
		nbb_s1 <= LW'(lb_sat * nbits);
		neg_s1 <= shift_count[CNT_W-1];
		mag_s1 <= cnt_mag;
	end

	// stage 2: operand masking, large shift compare, first remainder steps
	logic [DW-1:0] mask_a, mask_b;
	logic [LW-1:0] rem2, rem3, rem4, rem5;

	assign mask_a = ~({DW{1'b1}} << nba_s1);
	assign mask_b = ~({DW{1'b1}} << nbb_s1);

	bsl_rem_stage #(.DVW(LW)) u_rem2 (
		.cur_rem       ('0),
		.dividend_bits (mag_s1[31:24]),
		.divisor       (nba_s1),
		.next_rem      (rem2)
	);

	logic             vld_s2, neg_s2, big_s2;
	cmd_t             cmd_s2;
	logic [DW-1:0]    a_s2, b_s2;
	logic [LW-1:0]    la_s2, lb_s2, nba_s2, rem_s2;
	logic [CNT_W-1:0] mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		a_s2   <= a_s1 & mask_a;
		b_s2   <= b_s1 & mask_b;
		la_s2  <= la_s1;
		lb_s2  <= lb_s1;
		nba_s2 <= nba_s1;
		neg_s2 <= neg_s1;
		big_s2 <= mag_s1 >= CNT_W'(nba_s1);
		mag_s2 <= mag_s1;
		rem_s2 <= rem2;
	end

	// stages 3 to 5: remaining remainder steps
	bsl_rem_stage #(.DVW(LW)) u_rem3 (
		.cur_rem       (rem_s2),
		.dividend_bits (mag_s2[23:16]),
		.divisor       (nba_s2),
		.next_rem      (rem3)
	);

	logic             vld_s3, neg_s3, big_s3;
	cmd_t             cmd_s3;
	logic [DW-1:0]    a_s3, b_s3;
	logic [LW-1:0]    la_s3, lb_s3, nba_s3, rem_s3;
	logic [CNT_W-1:0] mag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		cmd_s3 <= cmd_s2;
		a_s3   <= a_s2;
		b_s3   <= b_s2;
		la_s3  <= la_s2;
		lb_s3  <= lb_s2;
		nba_s3 <= nba_s2;
		neg_s3 <= neg_s2;
		big_s3 <= big_s2;
		mag_s3 <= mag_s2;
		rem_s3 <= rem3;
	end

	bsl_rem_stage #(.DVW(LW)) u_rem4 (
		.cur_rem       (rem_s3),
		.dividend_bits (mag_s3[15:8]),
		.divisor       (nba_s3),
		.next_rem      (rem4)
	);

	logic             vld_s4, neg_s4, big_s4;
	cmd_t             cmd_s4;
	logic [DW-1:0]    a_s4, b_s4;
	logic [LW-1:0]    la_s4, lb_s4, nba_s4, rem_s4;
	logic [CNT_W-1:0] mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		cmd_s4 <= cmd_s3;
		a_s4   <= a_s3;
		b_s4   <= b_s3;
		la_s4  <= la_s3;
		lb_s4  <= lb_s3;
		nba_s4 <= nba_s3;
		neg_s4 <= neg_s3;
		big_s4 <= big_s3;
		mag_s4 <= mag_s3;
		rem_s4 <= rem4;
	end

	bsl_rem_stage #(.DVW(LW)) u_rem5 (
		.cur_rem       (rem_s4),
		.dividend_bits (mag_s4[7:0]),
		.divisor       (nba_s4),
		.next_rem      (rem5)
	);

	logic          vld_s5, neg_s5, big_s5;
	cmd_t          cmd_s5;
	logic [DW-1:0] a_s5, b_s5;
	logic [LW-1:0] la_s5, lb_s5, nba_s5, rem_s5, amt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		cmd_s5 <= cmd_s4;
		a_s5   <= a_s4;
		b_s5   <= b_s4;
		la_s5  <= la_s4;
		lb_s5  <= lb_s4;
		nba_s5 <= nba_s4;
		neg_s5 <= neg_s4;
		big_s5 <= big_s4;
		// only meaningful when the count is below the bit length
		amt_s5 <= mag_s4[LW-1:0];
		rem_s5 <= rem5;
	end

	// stage 6: command select and output register
	logic [DW-1:0] mask_r, res_d;
	logic [LW-1:0] rot_r, len_d;

	always_comb begin
		mask_r = ~({DW{1'b1}} << nba_s5);
		rot_r  = (neg_s5 && (rem_s5 != '0)) ? (nba_s5 - rem_s5) : rem_s5;
		len_d  = la_s5;
		unique case (cmd_s5)
			CMD_AND: begin
				res_d = a_s5 & b_s5;
				len_d = (la_s5 > lb_s5) ? la_s5 : lb_s5;
			end
			CMD_OR: begin
				res_d = a_s5 | b_s5;
				len_d = (la_s5 > lb_s5) ? la_s5 : lb_s5;
			end
			CMD_NOT: begin
				res_d = ~a_s5 & mask_r;
			end
			CMD_SHIFT: begin
				if (big_s5)      res_d = '0;
				else if (neg_s5) res_d = a_s5 >> amt_s5;
				else             res_d = (a_s5 << amt_s5) & mask_r;
			end
			CMD_ROTATE: begin
				res_d = ((a_s5 << rot_r) | (a_s5 >> (nba_s5 - rot_r))) & mask_r;
			end
			default: begin
				res_d = a_s5;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s5;
	end

	always_ff @(posedge clk) begin
		result     <= 64'(res_d);
		result_len <= LEN_PORT_W'(len_d);
	end

endmodule

`default_nettype wire

// ===== rtl/bsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsl_checker
	import bsl_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [LEN_PORT_W-1:0] result_len
);

	// every accepted item gives its result after the fixed latency
	a_fwd_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item gave no result");

	// no rising result strobe without an item accepted at the latency before
	a_bwd_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an item");

	// a result always has at least one digit
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_len != '0))
		else $error("result length is zero");

endmodule

bind bit_string_logic_shift_unit bsl_checker u_bsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.result_len (result_len)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bsl_pkg::*;

	// commands above CMD_ROTATE pass operand_a through
	localparam logic [2:0] CMD_PASS_LO = 3'd5;
	localparam logic [2:0] CMD_PASS_HI = 3'd7;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [63:0]           bits;
		logic [LEN_PORT_W-1:0] len;
	} bit_string_t;

	class bit_string_scoreboard;
		logic [1:0]  mode;
		bit_string_t expected_strings[$];
		int          errors;
		int          items_seen;
		int          results_seen;

		function new();
			mode = DM_OCT;
			errors = 0;
			items_seen = 0;
			results_seen = 0;
		endfunction

		function int unsigned digit_width();
			if (mode == DM_BIN)
				return 1;
			if (mode == DM_HEX)
				return 4;
			return 3;
		endfunction

		function logic [63:0] width_mask(input int unsigned n);
			if (n >= 64)
				return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		function int unsigned clamp_len(input logic [LEN_PORT_W-1:0] len);
			int unsigned top;
			top = 64 / digit_width();
			if (len == 0)
				return 1;
			if (len > top)
				return top;
			return len;
		endfunction

		function void write_mode(input logic [1:0] value);
			// the undefined mode code leaves the register alone
			if (value != DM_UNDEF)
				mode = value;
		endfunction

		function bit_string_t shift_logic_result(input logic [2:0] c, input logic [63:0] a_in,
				input logic [LEN_PORT_W-1:0] la_in, input logic [63:0] b_in,
				input logic [LEN_PORT_W-1:0] lb_in, input logic [31:0] cnt);
			int unsigned bits, la, lb, nba, r, rl;
			logic [63:0] a, b, res, m;
			logic neg;
			logic [31:0] mag;
			bit_string_t out;
			bits = digit_width();
			la = clamp_len(la_in);
			lb = clamp_len(lb_in);
			nba = la * bits;
			m = width_mask(nba);
			a = a_in & m;
			b = b_in & width_mask(lb * bits);
			neg = cnt[31];
			mag = neg ? (~cnt + 32'd1) : cnt;
			rl = la;
			case (c)
				CMD_AND, CMD_OR: begin
					rl = (la > lb) ? la : lb;
					res = (c == CMD_AND) ? (a & b) : (a | b);
					res &= width_mask(rl * bits);
				end
				CMD_NOT: res = ~a & m;
				CMD_SHIFT: begin
					if (mag == 0)
						res = a;
					else if (mag >= nba)
						res = '0;
					else if (neg)
						res = a >> mag;
					else
						res = (a << mag) & m;
				end
				CMD_ROTATE: begin
					r = mag % nba;
					if (neg && r != 0)
						r = nba - r;
					if (r == 0)
						res = a;
					else
						res = ((a << r) | (a >> (nba - r))) & m;
				end
				default: res = a;
			endcase
			out.bits = res;
			out.len = rl[LEN_PORT_W-1:0];
			return out;
		endfunction

		function void note_item(input logic [2:0] c, input logic [63:0] a,
				input logic [LEN_PORT_W-1:0] la, input logic [63:0] b,
				input logic [LEN_PORT_W-1:0] lb, input logic [31:0] cnt);
			expected_strings.push_back(shift_logic_result(c, a, la, b, lb, cnt));
			items_seen++;
		endfunction

		function void check_result(input logic [63:0] bits, input logic [LEN_PORT_W-1:0] len);
			bit_string_t exp_s;
			results_seen++;
			if (expected_strings.size() == 0) begin
				$display("%0t: result with no item waiting: actual %h len %0d", $time, bits, len);
				errors++;
				return;
			end
			exp_s = expected_strings.pop_front();
			if (bits !== exp_s.bits) begin
				$display("%0t: result mismatch: expected %h actual %h", $time, exp_s.bits, bits);
				errors++;
			end
			if (len !== exp_s.len) begin
				$display("%0t: result_len mismatch: expected %0d actual %0d",
					$time, exp_s.len, len);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [2:0]            cmd = CMD_AND;
	logic [63:0]           operand_a = '0;
	logic [LEN_PORT_W-1:0] len_a = 1;
	logic [63:0]           operand_b = '0;
	logic [LEN_PORT_W-1:0] len_b = 1;
	logic [31:0]           shift_count = '0;
	logic                  cfg_wr_en = 1'b0;
	logic [1:0]            cfg_wr_data = DM_OCT;
	logic                  done;
	logic [63:0]           result;
	logic [LEN_PORT_W-1:0] result_len;

	bit_string_scoreboard sb = new();
	int cfg_writes = 0;
	int mode_hits[4] = '{0, 0, 0, 0};

	bit_string_logic_shift_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.operand_a  (operand_a),
		.len_a      (len_a),
		.operand_b  (operand_b),
		.len_b      (len_b),
		.shift_count(shift_count),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.result     (result),
		.result_len (result_len)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result, result_len);
			if (start && !busy) begin
				sb.note_item(cmd, operand_a, len_a, operand_b, len_b, shift_count);
				mode_hits[sb.mode]++;
			end
			if (cfg_wr_en)
				sb.write_mode(cfg_wr_data);
		end
	end

	initial begin
		#2_000_000;
		$display("bit_string_logic_shift_unit regression: fail");
		$finish;
	end

	// called just after a rising edge; returns at the edge that accepts the item
	task automatic send_item(input logic [2:0] c, input logic [63:0] a,
			input logic [LEN_PORT_W-1:0] la, input logic [63:0] b,
			input logic [LEN_PORT_W-1:0] lb, input logic [31:0] cnt);
		cmd <= c;
		operand_a <= a;
		len_a <= la;
		operand_b <= b;
		len_b <= lb;
		shift_count <= cnt;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (sb.expected_strings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2)
			@(posedge clk);
	endtask

	task automatic write_digit_mode(input logic [1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
		// let the scoreboard pick up the new mode before the next item is built
		@(posedge clk);
	endtask

	task automatic send_random(input bit gappy);
		logic [2:0] c;
		logic [63:0] a, b;
		logic [LEN_PORT_W-1:0] la, lb;
		logic [31:0] cnt;
		int unsigned top, pick;
		top = 64 / sb.digit_width();
		pick = $urandom_range(0, 19);
		c = (pick < 18) ? 3'(pick % 5) : 3'($urandom_range(CMD_PASS_LO, CMD_PASS_HI));
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0)
			a = '1;
		else if (pick == 1)
			b = '0;
		pick = $urandom_range(0, 9);
		la = LEN_PORT_W'((pick == 0) ? $urandom_range(0, 127) : (pick == 1) ? top :
			(pick == 2) ? 1 : $urandom_range(1, top));
		pick = $urandom_range(0, 9);
		lb = LEN_PORT_W'((pick == 0) ? $urandom_range(0, 127) : (pick == 1) ? top :
			(pick == 2) ? 1 : $urandom_range(1, top));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			cnt = $urandom;
		else if (pick == 1)
			cnt = ($urandom_range(0, 2) == 0) ? 32'h8000_0000 :
				($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h0;
		else
			cnt = $urandom_range(0, 136) - 68;
		send_item(c, a, la, b, lb, cnt);
		if (gappy && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	initial begin
		logic [1:0] phase_modes[7];
		logic [63:0] mix;
		phase_modes = '{DM_BIN, DM_HEX, DM_UNDEF, DM_OCT, DM_BIN, DM_HEX, DM_OCT};
		mix = {$urandom, $urandom};
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_digit_mode(DM_OCT);

		// octal: 21 digits make 63 bits
		send_item(CMD_AND, '1, 21, 64'h0f0f_0f0f_0f0f_0f0f, 5, 0);
		send_item(CMD_OR, 64'h123, 2, '1, 21, 0);
		send_item(CMD_AND, '1, 0, '1, 127, 0);
		send_item(CMD_NOT, '0, 21, '0, 1, 0);
		send_item(CMD_NOT, '1, 1, '0, 1, 0);
		send_item(CMD_SHIFT, '1, 21, '0, 1, 1);
		send_item(CMD_SHIFT, '1, 21, '0, 1, -1);
		send_item(CMD_SHIFT, '1, 21, '0, 1, 0);
		send_item(CMD_SHIFT, '1, 21, '0, 1, 63);
		send_item(CMD_SHIFT, '1, 21, '0, 1, -63);
		send_item(CMD_SHIFT, mix, 21, '0, 1, 62);
		send_item(CMD_SHIFT, mix, 21, '0, 1, 32'h8000_0000);
		send_item(CMD_SHIFT, mix, 21, '0, 1, 32'h7fff_ffff);
		send_item(CMD_ROTATE, mix, 21, '0, 1, 1);
		send_item(CMD_ROTATE, mix, 21, '0, 1, -1);
		send_item(CMD_ROTATE, mix, 21, '0, 1, 0);
		send_item(CMD_ROTATE, mix, 21, '0, 1, 32'h8000_0000);
		send_item(CMD_ROTATE, mix, 7, '0, 1, 32'h7fff_ffff);
		send_item(CMD_ROTATE, mix, 7, '0, 1, -22);
		send_item(CMD_PASS_LO, '1, 127, '1, 127, 5);
		send_item(CMD_PASS_HI, 64'hdead, 3, '0, 1, 0);
		send_item(CMD_OR, '0, 64, '0, 64, 0);
		drain_results();

		for (int p = 0; p < 7; p++) begin
			write_digit_mode(phase_modes[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random(p < 6 && ((i / 20) % 2 == 0));
			drain_results();
		end

		$display("items %0d, results %0d, digit mode writes %0d (undefined code included)",
			sb.items_seen, sb.results_seen, cfg_writes);
		$display("items per mode: binary %0d, octal %0d, hex %0d",
			mode_hits[DM_BIN], mode_hits[DM_OCT], mode_hits[DM_HEX]);
		if (sb.errors == 0 && sb.expected_strings.size() == 0)
			$display("bit_string_logic_shift_unit regression: pass");
		else
			$display("bit_string_logic_shift_unit regression: fail");
		$finish;
	end

endmodule
